[src/lfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and helpers for the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int MAX_SAMPLES_DEF = 90;
    localparam int HEADER_BYTES    = 10;
    localparam int ANGLE_W         = 19;
    localparam int DIST_W          = 16;
    localparam int COUNT_W         = 8;
    localparam int FSZ_W           = 10;

    localparam logic [7:0]         SYNC0        = 8'hAA;
    localparam logic [7:0]         SYNC1        = 8'h55;
    localparam logic [ANGLE_W-1:0] FULL_TURN    = 19'd368640;
    localparam logic [DIST_W-1:0]  MIN_DIST_RST = 16'd200;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST = 16'hFFFF;

    localparam logic REG_MIN_DIST = 1'b0;
    localparam logic REG_MAX_DIST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_USE,
        ST_FR_RD,
        ST_FR_USE,
        ST_ANG,
        ST_DIV,
        ST_PT_RD,
        ST_PT_USE,
        ST_PUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_first;
        logic [DIST_W-1:0]  distance_first;
        logic               valid_first;
        logic [ANGLE_W-1:0] angle_second;
        logic [DIST_W-1:0]  distance_second;
        logic               valid_second;
        logic               second_present;
        logic               scan_start;
        logic               frame_last;
    } result_t;

    // raw angle word to 1/1024 degree, wrapped to one turn
    function automatic logic [ANGLE_W-1:0] angle_of(input logic [15:0] w);
        logic [ANGLE_W-1:0] a;
        a = {w[15:1], 4'b0000};
        if (a >= FULL_TURN) begin
            a = a - FULL_TURN;
        end
        return a;
    endfunction

endpackage
`default_nettype wire

[src/lfp_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_store
// Byte store for the frame parser: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfp_store #(
    parameter int DEPTH  = 190,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/lfp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_div
// Restoring divider, one quotient bit per cycle. Results hold until the
// next start.
// ----------------------------------------------------------------------------
module lfp_div
    import lfp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [ANGLE_W-1:0] dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic      [ANGLE_W-1:0] quot,
    output logic      [COUNT_W-1:0] rem,
    output logic                    done
);

    localparam int CNT_W = $clog2(ANGLE_W + 1);

    logic [ANGLE_W-1:0] quot_reg, quot_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;

    assign trial = {rem_reg, quot_reg[ANGLE_W-1]};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = COUNT_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[ANGLE_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[COUNT_W-1:0];
                quot_next = {quot_reg[ANGLE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ANGLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[src/lidar_frame_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_frame_parser_core
// Byte-serial parser for AA 55 framed lidar data with XOR word checksum.
// Emits up to two points per result word.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   s_       | s_valid / s_ready  | s_data_byte
//   m_       | m_valid / m_ready  | angles, distances, flags, m_last
//   cfg_     | cfg_we             | cfg_index, cfg_wdata
//
// Each byte rescans the store from its head; every byte of it is read from
// the byte store through its single registered read port (a read state,
// then a use state). A finished frame adds an angle-span divide (a set-up
// state, 19 quotient bits, then a wait to see done) plus two byte reads per
// point and a push per result word.
// Reset is synchronous; the store needs no clearing pass, only fill count.
// The output register and one held word free the parser: it stalls when a
// third result waits behind two, or at a pass end until the held word moves.
// ----------------------------------------------------------------------------
module lidar_frame_parser_core
    import lfp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [ANGLE_W-1:0]      m_angle_first,
    output logic [DIST_W-1:0]       m_distance_first,
    output logic                    m_valid_first,
    output logic [ANGLE_W-1:0]      m_angle_second,
    output logic [DIST_W-1:0]       m_distance_second,
    output logic                    m_valid_second,
    output logic                    m_second_present,
    output logic                    m_scan_start,
    output logic                    m_frame_last,
    output logic                    m_last,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [DIST_W-1:0]  cfg_wdata
);

    localparam int STORE_BYTES = HEADER_BYTES + 2 * MAX_SAMPLES;
    localparam int PTR_W       = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);

    localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(STORE_BYTES);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_BYTES);
    localparam logic [CNT_W-1:0] HDR_C    = CNT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HEADER_BYTES - 1);
    localparam logic [FSZ_W-1:0] HDR_F    = FSZ_W'(HEADER_BYTES);
    localparam logic [7:0]       MAX_N    = 8'(MAX_SAMPLES);

    state_t state_reg, state_next;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               aa_reg, aa_next;
    logic [15:0]        acc_reg, acc_next;
    logic               scan_reg, scan_next;
    logic [7:0]         n_reg, n_next;
    logic [15:0]        ws_reg, ws_next;
    logic [15:0]        we_reg, we_next;
    logic [ANGLE_W-1:0] start_reg, start_next;
    logic [ANGLE_W-1:0] q_reg, q_next;
    logic [COUNT_W-1:0] r_reg, r_next;
    logic [8:0]         idx_reg, idx_next;
    logic               slot_reg, slot_next;
    logic [7:0]         lo_reg, lo_next;
    result_t            res_reg, res_next;
    result_t            pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic [DIST_W-1:0]  min_reg, max_reg;

    // store ports
    logic             st_we;
    logic [PTR_W-1:0] st_waddr, st_raddr;
    logic [7:0]       rdata;

    // divider
    logic               div_start, div_done;
    logic [ANGLE_W-1:0] div_quot, span;
    logic [COUNT_W-1:0] div_rem, den;

    // shared decode
    logic               accept, fill_full, scan_end, sync_hit, hdr_done, n_bad;
    logic               short_frame, body_end, out_free, push_go, pt_more;
    logic [CNT_W-1:0]   h_pos, fill_after_h;
    logic [FSZ_W-1:0]   fsz;
    logic [15:0]        acc_new;
    logic               drop_en;
    logic [CNT_W-1:0]   drop_amt;
    logic [CNT_W:0]     ra_sum, wa_sum, hd_sum;
    logic [ANGLE_W-1:0] a_start, a_end;
    logic [ANGLE_W:0]   ang_sum;
    logic [ANGLE_W-1:0] ang_pt;
    logic [DIST_W-1:0]  dist_pt;
    logic               ok_pt;
    logic [COUNT_W:0]   r_sum;
    logic               r_wrap;

    assign accept       = s_valid && s_ready;
    assign fill_full    = fill_reg == DEPTH_C;
    assign scan_end     = k_reg == fill_reg;
    assign sync_hit     = aa_reg && (rdata == SYNC1);
    assign h_pos        = k_reg - 1'b1;
    assign fill_after_h = fill_reg - h_pos;
    assign hdr_done     = k_reg == HDR_LAST;
    assign n_bad        = (n_reg == 8'd0) || (n_reg > MAX_N);
    assign fsz          = HDR_F + {1'b0, n_reg, 1'b0};
    assign short_frame  = FSZ_W'(fill_reg) < fsz;
    assign body_end     = (k_reg > HDR_LAST) && (FSZ_W'(k_reg) == fsz - 1'b1);
    assign acc_new      = k_reg[0] ? (acc_reg ^ {rdata, 8'h00}) : (acc_reg ^ {8'h00, rdata});
    assign out_free     = !out_valid_reg || m_ready;
    assign push_go      = !pend_valid_reg || out_free;
    assign pt_more      = !slot_reg && ((idx_reg + 9'd1) < {1'b0, n_reg});
    assign den          = (n_reg > 8'd1) ? (n_reg - 8'd1) : 8'd1;

    // circular addressing
    assign ra_sum   = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(k_reg);
    assign st_raddr = (ra_sum >= DEPTH_X) ? PTR_W'(ra_sum - DEPTH_X) : PTR_W'(ra_sum);
    assign wa_sum   = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(fill_reg);
    assign st_waddr = fill_full ? head_reg :
                      ((wa_sum >= DEPTH_X) ? PTR_W'(wa_sum - DEPTH_X) : PTR_W'(wa_sum));
    assign hd_sum   = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(drop_amt);
    assign st_we    = accept;

    // frame angles
    assign a_start   = angle_of(ws_reg);
    assign a_end     = angle_of(we_reg);
    assign span      = (a_end >= a_start) ? (a_end - a_start) : (a_end + FULL_TURN - a_start);
    assign div_start = state_reg == ST_ANG;

    // per-point angle and validity
    assign ang_sum = {1'b0, start_reg} + {1'b0, q_reg};
    assign ang_pt  = (ang_sum >= {1'b0, FULL_TURN}) ? ANGLE_W'(ang_sum - {1'b0, FULL_TURN})
                                                  : ang_sum[ANGLE_W-1:0];
    assign dist_pt = {rdata, lo_reg};
    assign ok_pt   = (dist_pt != '0) && (dist_pt >= min_reg) && (dist_pt <= max_reg);
    assign r_sum   = {1'b0, r_reg} + {1'b0, div_rem};
    assign r_wrap  = r_sum >= {1'b0, den};

    lfp_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_data_byte),
        .raddr (st_raddr),
        .rdata (rdata)
    );

    lfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (span),
        .divisor  (den),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = scan_end ? ST_DONE : ST_SCAN_USE;
            ST_SCAN_USE: begin
                if (sync_hit) begin
                    state_next = (fill_after_h >= HDR_C) ? ST_FR_RD : ST_DONE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FR_RD:    state_next = ST_FR_USE;
            ST_FR_USE: begin
                priority if (hdr_done) begin
                    state_next = n_bad ? ST_SCAN_RD : (short_frame ? ST_DONE : ST_FR_RD);
                end else if (body_end) begin
                    state_next = (acc_new != 16'h0000) ? ST_SCAN_RD : ST_ANG;
                end else begin
                    state_next = ST_FR_RD;
                end
            end
            ST_ANG:      state_next = ST_DIV;
            ST_DIV:      if (div_done) state_next = ST_PT_RD;
            ST_PT_RD:    state_next = ST_PT_USE;
            ST_PT_USE: begin
                if (!k_reg[0] || pt_more) begin
                    state_next = ST_PT_RD;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_go) begin
                    state_next = res_reg.frame_last ? ST_SCAN_RD : ST_PT_RD;
                end
            end
            ST_DONE:     if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready         = state_reg == ST_IDLE;
        head_next       = head_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        aa_next         = aa_reg;
        acc_next        = acc_reg;
        scan_next       = scan_reg;
        n_next          = n_reg;
        ws_next         = ws_reg;
        we_next         = we_reg;
        start_next      = start_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        lo_next         = lo_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        drop_en         = 1'b0;
        drop_amt        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // full store: drop the oldest byte, count stays
                    if (fill_full) begin
                        head_next = (head_reg == PTR_W'(STORE_BYTES - 1)) ? '0
                                                                         : head_reg + 1'b1;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                    k_next  = '0;
                    aa_next = 1'b0;
                end
            end
            ST_SCAN_RD: begin
                if (scan_end && (fill_reg > CNT_W'(1))) begin
                    drop_en  = 1'b1;
                    drop_amt = fill_reg - 1'b1;
                end
            end
            ST_SCAN_USE: begin
                if (sync_hit) begin
                    drop_en  = 1'b1;
                    drop_amt = h_pos;
                    k_next   = '0;
                    acc_next = '0;
                end else begin
                    aa_next = rdata == SYNC0;
                    k_next  = k_reg + 1'b1;
                end
            end
            ST_FR_RD: begin
            end
            ST_FR_USE: begin
                acc_next = acc_new;
                case (k_reg)
                    CNT_W'(2): scan_next = rdata[0];
                    CNT_W'(3): n_next = rdata;
                    CNT_W'(4): ws_next[7:0] = rdata;
                    CNT_W'(5): ws_next[15:8] = rdata;
                    CNT_W'(6): we_next[7:0] = rdata;
                    CNT_W'(7): we_next[15:8] = rdata;
                    default: ;
                endcase
                k_next = k_reg + 1'b1;
                priority if (hdr_done) begin
                    if (n_bad) begin
                        drop_en  = 1'b1;
                        drop_amt = CNT_W'(1);
                        k_next   = '0;
                        aa_next  = 1'b0;
                    end
                end else if (body_end) begin
                    if (acc_new != 16'h0000) begin
                        drop_en  = 1'b1;
                        drop_amt = CNT_W'(1);
                        k_next   = '0;
                        aa_next  = 1'b0;
                    end
                end else begin
                end
            end
            ST_ANG: begin
                start_next = a_start;
            end
            ST_DIV: begin
                k_next    = HDR_C;
                q_next    = '0;
                r_next    = '0;
                idx_next  = '0;
                slot_next = 1'b0;
            end
            ST_PT_RD: begin
            end
            ST_PT_USE: begin
                k_next = k_reg + 1'b1;
                if (!k_reg[0]) begin
                    lo_next = rdata;
                end else begin
                    if (!slot_reg) begin
                        res_next                = '0;
                        res_next.angle_first    = ang_pt;
                        res_next.distance_first = dist_pt;
                        res_next.valid_first    = ok_pt;
                    end else begin
                        res_next.angle_second    = ang_pt;
                        res_next.distance_second = dist_pt;
                        res_next.valid_second    = ok_pt;
                    end
                    res_next.scan_start     = scan_reg;
                    res_next.second_present = slot_reg;
                    res_next.frame_last     = !pt_more && ((idx_reg + 9'd1) >= {1'b0, n_reg});
                    // advance the interpolated offset by span / den
                    r_next    = r_wrap ? COUNT_W'(r_sum - {1'b0, den}) : r_sum[COUNT_W-1:0];
                    q_next    = q_reg + div_quot + ANGLE_W'(r_wrap);
                    idx_next  = idx_reg + 9'd1;
                    slot_next = pt_more;
                end
            end
            ST_PUSH: begin
                if (push_go) begin
                    if (pend_valid_reg) begin
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = res_reg;
                    pend_valid_next = 1'b1;
                    slot_next       = 1'b0;
                    if (res_reg.frame_last) begin
                        drop_en  = 1'b1;
                        drop_amt = CNT_W'(fsz);
                        k_next   = '0;
                        aa_next  = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (pend_valid_reg && out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase

        if (drop_en) begin
            head_next = (hd_sum >= DEPTH_X) ? PTR_W'(hd_sum - DEPTH_X) : PTR_W'(hd_sum);
            fill_next = fill_reg - drop_amt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            k_reg          <= '0;
            aa_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            min_reg        <= MIN_DIST_RST;
            max_reg        <= MAX_DIST_RST;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            k_reg          <= k_next;
            aa_reg         <= aa_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MIN_DIST: min_reg <= cfg_wdata;
                    REG_MAX_DIST: max_reg <= cfg_wdata;
                endcase
            end
        end
        acc_reg      <= acc_next;
        scan_reg     <= scan_next;
        n_reg        <= n_next;
        ws_reg       <= ws_next;
        we_reg       <= we_next;
        start_reg    <= start_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        lo_reg       <= lo_next;
        res_reg      <= res_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_angle_first     = out_reg.angle_first;
    assign m_distance_first  = out_reg.distance_first;
    assign m_valid_first     = out_reg.valid_first;
    assign m_angle_second    = out_reg.angle_second;
    assign m_distance_second = out_reg.distance_second;
    assign m_valid_second    = out_reg.valid_second;
    assign m_second_present  = out_reg.second_present;
    assign m_scan_start      = out_reg.scan_start;
    assign m_frame_last      = out_reg.frame_last;
    assign m_last            = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond store depth");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind at idle");

    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && pend_valid_reg && out_valid_reg && !m_ready)
            |=> (state_reg == ST_PUSH))
        else $error("result pushed over a stalled output");

endmodule
`default_nettype wire

[tb/lidar_frame_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser_core_tb
// Feeds sync-framed byte streams (good frames, bad counts, bad checksums,
// noise) into the parser and checks every point pair against a local model
// of the parser, under several sender and receiver stall patterns and
// several distance threshold settings.
// ----------------------------------------------------------------------------
module lidar_frame_parser_core_tb;
    import lfp_pkg::*;

    localparam int STORE_DEPTH = HEADER_BYTES + 2 * MAX_SAMPLES_DEF;
    localparam int SETTLE_CYC  = 600;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [ANGLE_W-1:0] angle_first;
        logic [DIST_W-1:0]  distance_first;
        logic               valid_first;
        logic [ANGLE_W-1:0] angle_second;
        logic [DIST_W-1:0]  distance_second;
        logic               valid_second;
        logic               second_present;
        logic               scan_start;
        logic               frame_last;
        logic               last;
    } point_pair_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [7:0] s_data_byte;
    logic m_valid;
    logic m_ready;
    logic [ANGLE_W-1:0] m_angle_first;
    logic [DIST_W-1:0]  m_distance_first;
    logic               m_valid_first;
    logic [ANGLE_W-1:0] m_angle_second;
    logic [DIST_W-1:0]  m_distance_second;
    logic               m_valid_second;
    logic               m_second_present;
    logic               m_scan_start;
    logic               m_frame_last;
    logic               m_last;
    logic               cfg_we;
    logic               cfg_index;
    logic [DIST_W-1:0]  cfg_wdata;

    lidar_frame_parser_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_angle_first     (m_angle_first),
        .m_distance_first  (m_distance_first),
        .m_valid_first     (m_valid_first),
        .m_angle_second    (m_angle_second),
        .m_distance_second (m_distance_second),
        .m_valid_second    (m_valid_second),
        .m_second_present  (m_second_present),
        .m_scan_start      (m_scan_start),
        .m_frame_last      (m_frame_last),
        .m_last            (m_last),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // parser model state
    logic [7:0]  rx_store [STORE_DEPTH];
    int          rx_fill;
    logic [15:0] min_dist;
    logic [15:0] max_dist;

    point_pair_t expected_pairs [$];
    logic [7:0]  tx_bytes [$];
    int          mismatches;
    int          cycles;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_request;
    int          hold_left;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic void tx_add(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    function automatic void pair_add(input point_pair_t pp);
        expected_pairs.insert(expected_pairs.size(), pp);
    endfunction

    function automatic int unsigned turn_angle(input logic [15:0] w);
        int unsigned a;
        a = int'(w >> 1) * 16;
        if (a >= FULL_TURN) begin
            a = a - FULL_TURN;
        end
        return a;
    endfunction

    function automatic logic [15:0] store_word(input int off);
        return {rx_store[off + 1], rx_store[off]};
    endfunction

    function automatic void drop_bytes(input int k);
        if (k >= rx_fill) begin
            rx_fill = 0;
        end else begin
            for (int j = 0; j < rx_fill - k; j++) begin
                rx_store[j] = rx_store[j + k];
            end
            rx_fill = rx_fill - k;
        end
    endfunction

    function automatic logic dist_ok(input logic [15:0] d);
        return d != 0 && d >= min_dist && d <= max_dist;
    endfunction

    function automatic void queue_frame_points(input int n);
        int unsigned start_a;
        int unsigned end_a;
        int unsigned span;
        int unsigned den;
        longint unsigned off;
        point_pair_t pp;
        logic [15:0] d;
        start_a = turn_angle(store_word(4));
        end_a   = turn_angle(store_word(6));
        span    = (end_a >= start_a) ? end_a - start_a : end_a + FULL_TURN - start_a;
        den     = (n > 1) ? n - 1 : 1;
        for (int i = 0; i < n; i += 2) begin
            pp = '{default: '0};
            for (int k = 0; k < 2 && i + k < n; k++) begin
                off = (longint'(span) * (i + k)) / den;
                d   = store_word(HEADER_BYTES + 2 * (i + k));
                if (k == 0) begin
                    pp.angle_first    = ANGLE_W'((start_a + off) % FULL_TURN);
                    pp.distance_first = d;
                    pp.valid_first    = dist_ok(d);
                end else begin
                    pp.angle_second    = ANGLE_W'((start_a + off) % FULL_TURN);
                    pp.distance_second = d;
                    pp.valid_second    = dist_ok(d);
                end
            end
            pp.second_present = (i + 1 < n);
            pp.scan_start     = rx_store[2][0];
            pp.frame_last     = (i + 2 >= n);
            pp.last           = 1'b0;
            pair_add(pp);
        end
    endfunction

    // append one byte and parse every frame it completes
    function automatic void parse_byte(input logic [7:0] b);
        int head;
        int n;
        int fsz;
        int pushed;
        logic [15:0] sum;
        pushed = expected_pairs.size();
        if (rx_fill >= STORE_DEPTH) begin
            drop_bytes(1);
        end
        rx_store[rx_fill] = b;
        rx_fill++;
        forever begin
            head = rx_fill;
            for (int i = 0; i + 1 < rx_fill; i++) begin
                if (rx_store[i] == SYNC0 && rx_store[i + 1] == SYNC1) begin
                    head = i;
                    break;
                end
            end
            if (head == rx_fill) begin
                if (rx_fill > 1) begin
                    drop_bytes(rx_fill - 1);
                end
                break;
            end
            if (head > 0) begin
                drop_bytes(head);
            end
            if (rx_fill < HEADER_BYTES) begin
                break;
            end
            n = rx_store[3];
            if (n == 0 || n > MAX_SAMPLES_DEF) begin
                drop_bytes(1);
                continue;
            end
            fsz = HEADER_BYTES + 2 * n;
            if (rx_fill < fsz) begin
                break;
            end
            sum = 16'h0;
            for (int off = 0; off < 8; off += 2) begin
                sum ^= store_word(off);
            end
            for (int off = HEADER_BYTES; off + 1 < fsz; off += 2) begin
                sum ^= store_word(off);
            end
            if (sum != store_word(8)) begin
                drop_bytes(1);
                continue;
            end
            queue_frame_points(n);
            drop_bytes(fsz);
        end
        if (expected_pairs.size() > pushed) begin
            expected_pairs[expected_pairs.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
            end
        end
    endfunction

    always @(posedge aclk) begin
        point_pair_t pp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: unexpected result word");
                end
            end else begin
                pp = expected_pairs.pop_front();
                compare_field("angle_first", pp.angle_first, m_angle_first);
                compare_field("distance_first", pp.distance_first, m_distance_first);
                compare_field("valid_first", pp.valid_first, m_valid_first);
                compare_field("angle_second", pp.angle_second, m_angle_second);
                compare_field("distance_second", pp.distance_second, m_distance_second);
                compare_field("valid_second", pp.valid_second, m_valid_second);
                compare_field("second_present", pp.second_present, m_second_present);
                compare_field("scan_start", pp.scan_start, m_scan_start);
                compare_field("frame_last", pp.frame_last, m_frame_last);
                compare_field("last", pp.last, m_last);
            end
        end
    end

    // entered and left at a rising edge
    task automatic send_byte(input logic [7:0] b);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        parse_byte(b);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic flush_tx();
        while (tx_bytes.size() > 0) begin
            send_byte(tx_bytes.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_pairs.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_MIN_DIST) begin
            min_dist = value;
        end else begin
            max_dist = value;
        end
    endtask

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(min_dist + $urandom_range(2) - 1);
            3: return 16'(max_dist + $urandom_range(2) - 1);
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // queue one frame; dists shorter than n are padded with random picks
    function automatic void build_frame(input logic [7:0] ftype, input int n,
                                        input logic [15:0] sw, input logic [15:0] ew,
                                        input logic [15:0] dists [$], input logic bad_sum);
        logic [15:0] sum;
        while (dists.size() < n) begin
            dists.insert(dists.size(), pick_distance());
        end
        sum = {SYNC1, SYNC0} ^ {n[7:0], ftype} ^ sw ^ ew;
        foreach (dists[i]) begin
            sum ^= dists[i];
        end
        if (bad_sum) begin
            sum ^= 16'h1 << $urandom_range(15);
        end
        tx_add(SYNC0);
        tx_add(SYNC1);
        tx_add(ftype);
        tx_add(n[7:0]);
        tx_add(sw[7:0]);
        tx_add(sw[15:8]);
        tx_add(ew[7:0]);
        tx_add(ew[15:8]);
        tx_add(sum[7:0]);
        tx_add(sum[15:8]);
        foreach (dists[i]) begin
            tx_add(dists[i][7:0]);
            tx_add(dists[i][15:8]);
        end
    endfunction

    task automatic test_directed();
        logic [15:0] none [$];
        // noise ahead of sync, then single-point frame with extreme words
        tx_add(8'h00);
        tx_add(SYNC0);
        tx_add(8'hFF);
        build_frame(8'hFF, 1, 16'hFFFF, 16'h0000, '{16'hFFFF}, 1'b0);
        // end below start wraps the span; zero distance is never valid
        build_frame(8'h00, 3, 16'hF000, 16'h0010, '{16'h0000, 16'd200, 16'd199}, 1'b0);
        flush_tx();
        // bad counts: zero and just above the limit
        build_frame(8'h01, 0, 16'h1234, 16'h5678, none, 1'b0);
        tx_add(SYNC0);
        tx_add(SYNC1);
        tx_add(8'h01);
        tx_add(8'(MAX_SAMPLES_DEF + 1));
        // checksum mismatch
        build_frame(8'h01, 2, 16'h0100, 16'h0200, none, 1'b1);
        build_frame(8'h01, 2, 16'h0100, 16'h0200, none, 1'b0);
        flush_tx();
    endtask

    // a long frame with a bad checksum hides two good frames; its last
    // byte completes both
    task automatic test_nested_frames();
        logic [15:0] inner [$];
        logic [7:0]  outer_head [$];
        build_frame(8'h01, 1, 16'h0400, 16'h0400, '{16'd500}, 1'b0);
        build_frame(8'h00, 1, 16'h0800, 16'h0900, '{16'd700}, 1'b0);
        for (int i = 0; i < tx_bytes.size(); i += 2) begin
            inner.insert(inner.size(), {tx_bytes[i + 1], tx_bytes[i]});
        end
        tx_bytes.delete();
        build_frame(8'h00, inner.size(), 16'h0000, 16'h0000, inner, 1'b1);
        flush_tx();
        wait_drained();
    endtask

    task automatic random_traffic(input int n_bytes);
        int sent_target;
        int n;
        logic [15:0] none [$];
        sent_target = n_bytes;
        while (sent_target > 0) begin
            case ($urandom_range(9))
                0: begin
                    repeat ($urandom_range(4, 1)) tx_add(8'($urandom_range(255)));
                end
                1: begin
                    build_frame(8'($urandom_range(255)), $urandom_range(8, 1),
                                16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                                none, 1'b1);
                end
                2: begin
                    // bad count, 0 or out of range
                    n = ($urandom_range(1) == 0) ? 0 : $urandom_range(255, MAX_SAMPLES_DEF + 1);
                    tx_add(SYNC0);
                    tx_add(SYNC1);
                    tx_add(8'($urandom_range(255)));
                    tx_add(n[7:0]);
                end
                default: begin
                    build_frame(8'($urandom_range(255)), $urandom_range(8, 1),
                                16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                                none, 1'b0);
                end
            endcase
            sent_target -= tx_bytes.size();
            flush_tx();
        end
    endtask

    task automatic test_full_frame();
        logic [15:0] none [$];
        build_frame(8'h01, MAX_SAMPLES_DEF, 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(16'hFFFF)), none, 1'b0);
        flush_tx();
    endtask

    // receiver holds off while the sender keeps offering bytes; two
    // eight-point frames give more result words than the block can hold
    task automatic test_backpressure();
        logic [15:0] none [$];
        hold_request = 3000;
        build_frame(8'h01, 8, 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(16'hFFFF)), none, 1'b0);
        build_frame(8'h00, 8, 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(16'hFFFF)), none, 1'b0);
        flush_tx();
        wait_drained();
        random_traffic(10);
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data_byte        = 8'h00;
        m_ready            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_MIN_DIST;
        cfg_wdata          = '0;
        cycles             = 0;
        mismatches         = 0;
        hold_request       = 0;
        hold_left          = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rx_fill            = 0;
        min_dist           = MIN_DIST_RST;
        max_dist           = MAX_DIST_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_nested_frames();
        random_traffic(20);

        sender_idle_pct = 84;
        write_reg(REG_MIN_DIST, 16'd0);
        write_reg(REG_MAX_DIST, 16'd0);
        random_traffic(20);

        receiver_stall_pct = 84;
        sender_idle_pct    = 0;
        write_reg(REG_MIN_DIST, 16'hFFFF);
        write_reg(REG_MAX_DIST, 16'hFFFF);
        random_traffic(20);
        test_full_frame();

        sender_idle_pct = 8;
        receiver_stall_pct = 8;
        write_reg(REG_MIN_DIST, 16'($urandom_range(16'h3FFF)));
        write_reg(REG_MAX_DIST, 16'($urandom_range(16'hFFFF, 16'h4000)));
        random_traffic(20);

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (mismatches == 0 && expected_pairs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
src/lfp_pkg.sv
src/lfp_store.sv
src/lfp_div.sv
src/lidar_frame_parser_core.sv
tb/lidar_frame_parser_core_tb.sv
